[hdl/mission_ring_queue_assert.svh]
// assertion macros for the mission ring queue
`ifndef MISSION_RING_QUEUE_ASSERT_SVH
`define MISSION_RING_QUEUE_ASSERT_SVH

`ifndef ASSERT_OFF

`define MRQ_ASSERT(name, prop, clk, rst_n) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("mrq assertion failed");

`define MRQ_ASSERT_IMPL(name, ante, cons, clk, rst_n) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mrq assertion failed");

`define MRQ_ASSERT_NEXT(name, ante, cons, clk, rst_n) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mrq assertion failed");

`else

`define MRQ_ASSERT(name, prop, clk, rst_n)
`define MRQ_ASSERT_IMPL(name, ante, cons, clk, rst_n)
`define MRQ_ASSERT_NEXT(name, ante, cons, clk, rst_n)

`endif

`endif

[hdl/mrq_pkg.sv]
// shared constants for the mission ring queue
`timescale 1ns / 1ps
`default_nettype none

package mrq_pkg;

  localparam int FuncBits     = 4;
  localparam int IdBits       = 8;
  localparam int PayloadIn    = 32;
  localparam int GotoBits     = 8;
  localparam int SlotOutBits  = 6;
  localparam int InDataBits   = 48;
  localparam int OutDataBits  = 64;

  localparam int DefSlots       = 16;
  localparam int DefPayloadBits = 32;

  localparam logic [FuncBits-1:0] FnAppend   = 4'd0;
  localparam logic [FuncBits-1:0] FnPrepend  = 4'd1;
  localparam logic [FuncBits-1:0] FnReplCur  = 4'd2;
  localparam logic [FuncBits-1:0] FnReplAll  = 4'd3;
  localparam logic [FuncBits-1:0] FnReplNext = 4'd4;
  localparam logic [FuncBits-1:0] FnLookup   = 4'd5;
  localparam logic [FuncBits-1:0] FnReadHead = 4'd6;
  localparam logic [FuncBits-1:0] FnGoto     = 4'd7;
  localparam logic [FuncBits-1:0] FnAdvance  = 4'd8;
  localparam logic [FuncBits-1:0] FnEnd      = 4'd9;

endpackage

`default_nettype wire

[hdl/mrq_ram.sv]
// generic single-port-write, registered-read ram
`timescale 1ns / 1ps
`default_nettype none

module mrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hdl/mrq_store.sv]
// entry store: ram plus per-slot valid bits so unwritten slots read as zero
`timescale 1ns / 1ps
`default_nettype none

module mrq_store #(
  parameter int SLOTS        = mrq_pkg::DefSlots,
  parameter int PAYLOAD_BITS = mrq_pkg::DefPayloadBits
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        we_i,
  input  wire logic [$clog2(SLOTS)-1:0]    waddr_i,
  input  wire logic [mrq_pkg::IdBits-1:0]  wid_i,
  input  wire logic [PAYLOAD_BITS-1:0]     wpl_i,
  input  wire logic                        re_i,
  input  wire logic [$clog2(SLOTS)-1:0]    raddr_i,
  output logic      [mrq_pkg::IdBits-1:0]  rid_o,
  output logic      [PAYLOAD_BITS-1:0]     rpl_o
);

  import mrq_pkg::*;

  localparam int W = IdBits + PAYLOAD_BITS;

  logic [SLOTS-1:0] valid_q;
  logic             rvalid_q;
  logic [W-1:0]     rdata;

  mrq_ram #(
    .WIDTH (W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we_i),
    .waddr_i (waddr_i),
    .wdata_i ({wid_i, wpl_i}),
    .re_i    (re_i),
    .raddr_i (raddr_i),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvalid_q <= valid_q[raddr_i];
      end
    end
  end

  // never-written slots read as zero
  assign rid_o = rvalid_q ? rdata[W-1:PAYLOAD_BITS] : '0;
  assign rpl_o = rvalid_q ? rdata[PAYLOAD_BITS-1:0] : '0;

endmodule

`default_nettype wire

[hdl/mission_ring_queue.sv]
// Ring queue of id/payload entries between a head and a tail slot. Entries live in
// one ram with a registered read. A command is taken when the queue is idle;
// commands that need no search (goto, advance, end, unknown codes, inserts with
// the uniqueness check off) go straight from idle to the execute state. Lookup,
// read head and inserts with the uniqueness check on walk the live entries through
// the ram read port, one per cycle, until a match or the tail, and then execute.
// A result waits in an output register while the next command starts.
`timescale 1ns / 1ps
`default_nettype none

module mission_ring_queue #(
  parameter int SLOTS        = mrq_pkg::DefSlots,
  parameter int PAYLOAD_BITS = mrq_pkg::DefPayloadBits
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // check_unique
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic                             cfg_data_i,
  // elem_id, payload, goto_slot
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [mrq_pkg::InDataBits-1:0]   s_axis_tdata,
  // func
  input  wire logic [mrq_pkg::FuncBits-1:0]     s_axis_tuser,
  // ok, restart_timer, out_slot, out_id, out_payload, head_slot, tail_slot
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic      [mrq_pkg::OutDataBits-1:0]  m_axis_tdata
);

  import mrq_pkg::*;

  `include "mission_ring_queue_assert.svh"

  localparam int SW = $clog2(SLOTS);
  localparam logic [SW-1:0] LastSlot = SW'(SLOTS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC
  } state_e;

  state_e                  state_q;
  logic [SW-1:0]           head_q, tail_q, ptr_q, rslot_q, fslot_q;
  logic                    pend_q, found_q, cu_q, m_valid_q;
  logic [FuncBits-1:0]     func_q;
  logic [IdBits-1:0]       id_q, fid_q;
  logic [PayloadIn-1:0]    pl_q;
  logic [GotoBits-1:0]     gslot_q;
  logic [PAYLOAD_BITS-1:0] fpl_q;
  logic [OutDataBits-1:0]  m_data_q;

  logic                    in_xfer, out_free, need_scan, hit, dup;
  logic                    mem_re, mem_we, x_we, x_ok, x_rs, x_entry;
  logic [SW-1:0]           x_waddr, x_head, x_tail, t_slot;
  logic [IdBits-1:0]       rid;
  logic [PAYLOAD_BITS-1:0] rpl, wpl;
  logic [63:0]             pl_ext, fpl_ext;
  logic [SlotOutBits-1:0]  o_slot;
  logic [IdBits-1:0]       o_id;
  logic [PayloadIn-1:0]    o_pl;

  function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
    return (s == LastSlot) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [SW-1:0] prev_slot(input logic [SW-1:0] s);
    return (s == '0) ? LastSlot : s - 1'b1;
  endfunction

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  assign need_scan = ((s_axis_tuser <= FnReplNext) && cu_q) ||
                     (s_axis_tuser == FnLookup) || (s_axis_tuser == FnReadHead);

  // read head matches the first live entry
  assign hit    = pend_q && ((func_q == FnReadHead) || (rid == id_q));
  assign mem_re = (state_q == ST_SCAN) && (ptr_q != tail_q) && !hit;
  assign dup    = (func_q <= FnReplNext) && cu_q && found_q;

  assign pl_ext  = 64'(pl_q);
  assign wpl     = pl_ext[PAYLOAD_BITS-1:0];
  assign fpl_ext = 64'(fpl_q);

  mrq_store #(
    .SLOTS        (SLOTS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (x_waddr),
    .wid_i   (id_q),
    .wpl_i   (wpl),
    .re_i    (mem_re),
    .raddr_i (ptr_q),
    .rid_o   (rid),
    .rpl_o   (rpl)
  );

  // command execution
  always_comb begin
    x_we    = 1'b0;
    x_ok    = 1'b0;
    x_rs    = 1'b0;
    x_entry = 1'b0;
    x_waddr = head_q;
    x_head  = head_q;
    x_tail  = tail_q;
    t_slot  = '0;
    if (!dup) begin
      case (func_q)
        FnAppend: begin
          t_slot = next_slot(tail_q);
          if (t_slot != head_q) begin
            x_we    = 1'b1;
            x_waddr = tail_q;
            x_tail  = t_slot;
            x_ok    = 1'b1;
          end
        end
        FnPrepend: begin
          t_slot = prev_slot(head_q);
          if (t_slot != tail_q) begin
            x_we    = 1'b1;
            x_waddr = t_slot;
            x_head  = t_slot;
            x_ok    = 1'b1;
            x_rs    = 1'b1;
          end
        end
        FnReplCur: begin
          x_we = 1'b1;
          x_ok = 1'b1;
          x_rs = 1'b1;
        end
        FnReplAll: begin
          x_we    = 1'b1;
          x_waddr = '0;
          x_head  = '0;
          x_tail  = SW'(1);
          x_ok    = 1'b1;
          x_rs    = 1'b1;
        end
        FnReplNext: begin
          t_slot  = next_slot(head_q);
          x_we    = 1'b1;
          x_waddr = t_slot;
          x_tail  = next_slot(t_slot);
          x_ok    = 1'b1;
        end
        FnLookup, FnReadHead: begin
          x_ok    = found_q;
          x_entry = found_q;
        end
        FnGoto: begin
          if (32'(gslot_q) < SLOTS) begin
            x_head = gslot_q[SW-1:0];
            x_ok   = 1'b1;
            x_rs   = 1'b1;
          end
        end
        FnAdvance: begin
          if (head_q != tail_q) begin
            x_head = next_slot(head_q);
            x_ok   = 1'b1;
            x_rs   = 1'b1;
          end
        end
        FnEnd: begin
          x_head = tail_q;
          x_ok   = 1'b1;
          x_rs   = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign mem_we = x_we && (state_q == ST_EXEC) && out_free;
  assign o_slot = x_entry ? SlotOutBits'(fslot_q) : '0;
  assign o_id   = x_entry ? fid_q : '0;
  assign o_pl   = x_entry ? fpl_ext[PayloadIn-1:0] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      head_q    <= '0;
      tail_q    <= '0;
      ptr_q     <= '0;
      rslot_q   <= '0;
      fslot_q   <= '0;
      pend_q    <= 1'b0;
      found_q   <= 1'b0;
      cu_q      <= 1'b1;
      m_valid_q <= 1'b0;
      func_q    <= '0;
      id_q      <= '0;
      pl_q      <= '0;
      gslot_q   <= '0;
      fid_q     <= '0;
      fpl_q     <= '0;
      m_data_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        cu_q <= cfg_data_i;
      end
      if ((state_q == ST_EXEC) && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            func_q  <= s_axis_tuser;
            id_q    <= s_axis_tdata[IdBits-1:0];
            pl_q    <= s_axis_tdata[IdBits +: PayloadIn];
            gslot_q <= s_axis_tdata[IdBits+PayloadIn +: GotoBits];
            ptr_q   <= head_q;
            pend_q  <= 1'b0;
            found_q <= 1'b0;
            state_q <= need_scan ? ST_SCAN : ST_EXEC;
          end
        end
        ST_SCAN: begin
          pend_q  <= mem_re;
          rslot_q <= ptr_q;
          if (mem_re) begin
            ptr_q <= next_slot(ptr_q);
          end
          if (hit) begin
            found_q <= 1'b1;
            fslot_q <= rslot_q;
            fid_q   <= rid;
            fpl_q   <= rpl;
            state_q <= ST_EXEC;
          end else if (!pend_q && (ptr_q == tail_q)) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (out_free) begin
            head_q    <= x_head;
            tail_q    <= x_tail;
            m_data_q  <= {4'b0, SlotOutBits'(x_tail), SlotOutBits'(x_head),
                          o_pl, o_id, o_slot, x_rs, x_ok};
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  `MRQ_ASSERT(a_slots_in_range, (32'(head_q) < SLOTS) && (32'(tail_q) < SLOTS), clk_i, rst_ni)
  `MRQ_ASSERT_IMPL(a_write_in_exec, mem_we, state_q == ST_EXEC, clk_i, rst_ni)
  `MRQ_ASSERT_NEXT(a_xfer_leaves_idle, in_xfer, state_q != ST_IDLE, clk_i, rst_ni)
  `MRQ_ASSERT_IMPL(a_result_from_exec, $rose(m_valid_q), $past(state_q == ST_EXEC), clk_i, rst_ni)

endmodule

`default_nettype wire

[tb/mission_ring_queue_test.sv]
// testbench for the mission ring queue: predicted command results checked transfer by transfer
`timescale 1ns / 1ps

module mission_ring_queue_test;
  import mrq_pkg::*;

  localparam int Slots = 16;
  localparam int QuietLimit = 2000;
  localparam logic [FuncBits-1:0] FnFirstUnused = 4'd10;
  localparam logic [FuncBits-1:0] FnLastUnused  = 4'd15;

  typedef struct packed {
    logic        ok;
    logic        restart;
    logic [5:0]  slot;
    logic [7:0]  id;
    logic [31:0] payload;
    logic [5:0]  head;
    logic [5:0]  tail;
  } ring_result_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic                   cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [InDataBits-1:0]  s_axis_tdata;
  logic [FuncBits-1:0]    s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OutDataBits-1:0] m_axis_tdata;

  mission_ring_queue uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // queue model
  logic [7:0]  model_ids [Slots];
  logic [31:0] model_payloads [Slots];
  logic [3:0]  model_head;
  logic [3:0]  model_tail;
  logic        model_unique;

  ring_result_t pending_q[$];
  int n_items;
  int n_checked;
  int n_errors;
  int quiet_cycles;
  bit no_idle;
  bit rx_hold_req;
  int rx_hold_cycles;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic bit find_live(input logic [7:0] id, output logic [3:0] slot);
    logic [3:0] s;
    s = model_head;
    slot = '0;
    for (int n = 0; n < Slots && s != model_tail; n++) begin
      if (model_ids[s] == id) begin
        slot = s;
        return 1'b1;
      end
      s = s + 4'd1;
    end
    return 1'b0;
  endfunction

  function automatic ring_result_t predict_ring_step(input logic [3:0] func,
      input logic [7:0] id, input logic [31:0] pl, input logic [7:0] gslot);
    ring_result_t r;
    logic [3:0] s;
    logic [3:0] t;
    logic       dup;
    r = '0;
    dup = 1'b0;
    if (func <= FnReplNext && model_unique) dup = find_live(id, s);
    if (!dup) begin
      case (func)
        FnAppend: begin
          t = model_tail + 4'd1;
          if (t != model_head) begin
            model_ids[model_tail] = id;
            model_payloads[model_tail] = pl;
            model_tail = t;
            r.ok = 1'b1;
          end
        end
        FnPrepend: begin
          t = model_head - 4'd1;
          if (t != model_tail) begin
            model_ids[t] = id;
            model_payloads[t] = pl;
            model_head = t;
            r.ok = 1'b1;
            r.restart = 1'b1;
          end
        end
        FnReplCur: begin
          model_ids[model_head] = id;
          model_payloads[model_head] = pl;
          r.ok = 1'b1;
          r.restart = 1'b1;
        end
        FnReplAll: begin
          model_ids[0] = id;
          model_payloads[0] = pl;
          model_head = 4'd0;
          model_tail = 4'd1;
          r.ok = 1'b1;
          r.restart = 1'b1;
        end
        FnReplNext: begin
          model_ids[model_head + 4'd1] = id;
          model_payloads[model_head + 4'd1] = pl;
          model_tail = model_head + 4'd2;
          r.ok = 1'b1;
        end
        FnLookup: begin
          if (find_live(id, s)) begin
            r.ok = 1'b1;
            r.slot = 6'(s);
            r.id = model_ids[s];
            r.payload = model_payloads[s];
          end
        end
        FnReadHead: begin
          if (model_head != model_tail) begin
            r.ok = 1'b1;
            r.slot = 6'(model_head);
            r.id = model_ids[model_head];
            r.payload = model_payloads[model_head];
          end
        end
        FnGoto: begin
          if (gslot < Slots) begin
            model_head = gslot[3:0];
            r.ok = 1'b1;
            r.restart = 1'b1;
          end
        end
        FnAdvance: begin
          if (model_head != model_tail) begin
            model_head = model_head + 4'd1;
            r.ok = 1'b1;
            r.restart = 1'b1;
          end
        end
        FnEnd: begin
          model_head = model_tail;
          r.ok = 1'b1;
          r.restart = 1'b1;
        end
        default: ;
      endcase
    end
    r.head = 6'(model_head);
    r.tail = 6'(model_tail);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
      input logic [31:0] got);
    if (n_errors < 40)
      $display("mismatch at result %0d: %s expected %0h got %0h", n_checked, what, want, got);
    n_errors++;
  endtask

  // result checker
  always @(posedge clk_i) begin : result_check
    ring_result_t got;
    ring_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.ok      = m_axis_tdata[0];
      got.restart = m_axis_tdata[1];
      got.slot    = m_axis_tdata[7:2];
      got.id      = m_axis_tdata[15:8];
      got.payload = m_axis_tdata[47:16];
      got.head    = m_axis_tdata[53:48];
      got.tail    = m_axis_tdata[59:54];
      if (pending_q.size() == 0) begin
        report_mismatch("result with nothing pending", 32'd0, m_axis_tdata[31:0]);
      end else begin
        want = pending_q.pop_front();
        if (got.ok !== want.ok) report_mismatch("ok", want.ok, got.ok);
        if (got.restart !== want.restart) report_mismatch("restart_timer", want.restart,
            got.restart);
        if (got.slot !== want.slot) report_mismatch("out_slot", want.slot, got.slot);
        if (got.id !== want.id) report_mismatch("out_id", want.id, got.id);
        if (got.payload !== want.payload) report_mismatch("out_payload", want.payload,
            got.payload);
        if (got.head !== want.head) report_mismatch("head_slot", want.head, got.head);
        if (got.tail !== want.tail) report_mismatch("tail_slot", want.tail, got.tail);
      end
      n_checked++;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("watchdog: no transfer for %0d cycles", QuietLimit);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // receiver side
  initial begin
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk_i);
        rx_hold_req = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_cmd(input logic [3:0] func, input logic [7:0] id,
      input logic [31:0] pl, input logic [7:0] gslot);
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {gslot, pl, id};
    s_axis_tuser  <= func;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_q.push_back(predict_ring_step(func, id, pl, gslot));
    n_items++;
  endtask

  task automatic wait_results_done();
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_unique(input logic value);
    wait_results_done();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    model_unique = value;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_id();
    if ($urandom_range(0, 9) < 7) return 8'($urandom_range(0, 23));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_slot();
    if ($urandom_range(0, 4) != 0) return 8'($urandom_range(0, Slots - 1));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_random_cmd();
    int r;
    logic [3:0] f;
    r = $urandom_range(0, 99);
    if (r < 30) f = FnAppend;
    else if (r < 38) f = FnPrepend;
    else if (r < 44) f = FnReplCur;
    else if (r < 47) f = FnReplAll;
    else if (r < 52) f = FnReplNext;
    else if (r < 66) f = FnLookup;
    else if (r < 74) f = FnReadHead;
    else if (r < 80) f = FnGoto;
    else if (r < 88) f = FnAdvance;
    else if (r < 91) f = FnEnd;
    else f = 4'($urandom_range(0, 15));
    send_cmd(f, pick_id(), $urandom, pick_slot());
  endtask

  // restart the queue, fill it with distinct ids, then search and walk it
  task automatic send_fill_run();
    logic [7:0] base;
    int k;
    base = 8'($urandom);
    k = $urandom_range(2, Slots + 1);
    send_cmd(FnReplAll, base, $urandom, pick_slot());
    for (int i = 1; i < k; i++) send_cmd(FnAppend, 8'(base + i), $urandom, pick_slot());
    repeat ($urandom_range(1, 4))
      send_cmd(FnLookup, 8'(base + $urandom_range(0, k)), $urandom, pick_slot());
    send_cmd(FnPrepend, 8'(base - 1), $urandom, pick_slot());
    repeat ($urandom_range(0, 3)) send_cmd(FnAdvance, pick_id(), $urandom, pick_slot());
    send_cmd(FnReadHead, pick_id(), $urandom, pick_slot());
  endtask

  task automatic run_random(input int count);
    int stop;
    stop = n_items + count;
    while (n_items < stop) begin
      if ($urandom_range(0, 7) == 0) send_fill_run();
      else send_random_cmd();
    end
  endtask

  task automatic test_empty_queue();
    send_cmd(FnReadHead, 8'h00, 32'h0, 8'h00);
    send_cmd(FnLookup, 8'h00, 32'h0, 8'h00);
    send_cmd(FnAdvance, 8'h00, 32'h0, 8'h00);
    send_cmd(FnEnd, 8'h00, 32'h0, 8'h00);
  endtask

  task automatic test_each_command();
    send_cmd(FnAppend, 8'h00, 32'h0000_0000, 8'h00);
    send_cmd(FnAppend, 8'hff, 32'hffff_ffff, 8'hff);
    // duplicate id rejected
    send_cmd(FnAppend, 8'h00, 32'h1234_5678, 8'h00);
    send_cmd(FnLookup, 8'hff, 32'h0, 8'h00);
    send_cmd(FnLookup, 8'h55, 32'h0, 8'h00);
    send_cmd(FnReadHead, 8'h00, 32'h0, 8'h00);
    send_cmd(FnPrepend, 8'h07, 32'ha5a5_a5a5, 8'h00);
    send_cmd(FnReplCur, 8'hff, 32'h5a5a_5a5a, 8'h00);
    send_cmd(FnReplCur, 8'h09, 32'h0f0f_0f0f, 8'h00);
    send_cmd(FnReplNext, 8'h80, 32'hf0f0_f0f0, 8'h00);
    send_cmd(FnReplAll, 8'haa, 32'hdead_beef, 8'h00);
    send_cmd(FnGoto, 8'h00, 32'h0, 8'hff);
    send_cmd(FnGoto, 8'h00, 32'h0, 8'd16);
    send_cmd(FnGoto, 8'h00, 32'h0, 8'd15);
    send_cmd(FnAdvance, 8'h00, 32'h0, 8'h00);
    send_cmd(FnEnd, 8'h00, 32'h0, 8'h00);
    // replace current while empty
    send_cmd(FnReplCur, 8'h33, 32'h0000_0001, 8'h00);
    send_cmd(FnFirstUnused, 8'hff, 32'hffff_ffff, 8'hff);
    send_cmd(FnLastUnused, 8'h00, 32'h0, 8'h00);
    send_cmd(FnReplAll, 8'haa, 32'h1111_1111, 8'h00);
    set_unique(1'b0);
    send_cmd(FnAppend, 8'haa, 32'h2222_2222, 8'h00);
    send_cmd(FnLookup, 8'haa, 32'h0, 8'h00);
    set_unique(1'b1);
  endtask

  task automatic test_random_unique();
    set_unique(1'b1);
    run_random(450);
  endtask

  task automatic test_random_loose();
    set_unique(1'b0);
    run_random(450);
  endtask

  task automatic test_back_pressure();
    set_unique(1'b1);
    rx_hold_cycles = 120;
    rx_hold_req = 1'b1;
    run_random(30);
  endtask

  task automatic test_sender_pause();
    run_random(20);
    wait_results_done();
    repeat (10) @(posedge clk_i);
    run_random(20);
  endtask

  task automatic test_no_idle();
    wait_results_done();
    no_idle = 1'b1;
    run_random(180);
    set_unique(1'b0);
    run_random(180);
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    n_items = 0;
    n_checked = 0;
    n_errors = 0;
    quiet_cycles = 0;
    no_idle = 1'b0;
    rx_hold_req = 1'b0;
    rx_hold_cycles = 0;
    for (int i = 0; i < Slots; i++) begin
      model_ids[i] = '0;
      model_payloads[i] = '0;
    end
    model_head = '0;
    model_tail = '0;
    model_unique = 1'b1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_queue();
    test_each_command();
    test_random_unique();
    test_random_loose();
    test_back_pressure();
    test_sender_pause();
    test_no_idle();

    wait_results_done();
    repeat (40) @(posedge clk_i);
    if (pending_q.size() != 0)
      report_mismatch("results never delivered", 32'd0, pending_q.size());
    $display("ran %0d commands, checked %0d results, with the uniqueness check on and off",
             n_items, n_checked);
    $display("covered full and empty queues, duplicate ids, bad slots and output stalls");
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
